// ----- design/lpcd_pkg.sv -----
// Shared types and constants for the length-prefixed command deframer.
package lpcd_pkg;

   // Parser phase of the front end
   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_LENGTH = 2'd1,
      PH_DATA   = 2'd2
   } phase_type;

   // Kind of a result word
   typedef enum logic [1:0] {
      KIND_CMD      = 2'd0,
      KIND_SF       = 2'd1,
      KIND_SF_EMPTY = 2'd2,
      KIND_LEN_ERR  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  code;
      logic [7:0]  payload;
      logic        last;
   } result_type;

   localparam int BYTE_W          = 8;
   localparam int LEN_W           = 16;
   localparam int STRUCT_CODE_RST = 243;
   localparam int HEADER_BYTES    = 2;   // length bytes counted by the length itself
   localparam int SF_TYPE_INDEX   = 2;   // payload index of the structured field type
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

endpackage

// ----- design/lpcd_front.sv -----
// Front end: accepts stream bytes, tracks the frame and classifies each byte.
module lpcd_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   input  logic [7:0]              csr_data,
   input  logic                    in_valid,
   input  logic [7:0]              in_data,
   input  logic                    in_abort,
   input  logic                    queue_not_full,
   output logic                    push_valid,
   output lpcd_pkg::result_type    push_result
);

   lpcd_pkg::phase_type  phase_ff, phase_in;
   logic [7:0]           struct_code_ff;
   logic [7:0]           command_ff, command_in;
   logic                 sf_flag_ff, sf_flag_in;
   logic [7:0]           length_high_ff, length_high_in;
   logic                 low_seen_ff, low_seen_in;
   logic [15:0]          expected_ff, expected_in;
   logic [15:0]          count_ff, count_in;
   logic [7:0]           field_type_ff, field_type_in;

   logic                 accept;
   logic [15:0]          length_word;
   logic [15:0]          count_next;
   logic [15:0]          data_index;
   logic                 data_last;
   logic                 clear_frame;

   assign accept      = in_valid & queue_not_full;
   assign length_word = {length_high_ff, in_data};
   assign count_next  = count_ff + 16'd1;
   assign data_index  = count_ff - 16'(lpcd_pkg::HEADER_BYTES);
   assign data_last   = (count_next >= expected_ff);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (in_abort) begin
            phase_in = lpcd_pkg::PH_IDLE;
         end else begin
            unique case (phase_ff)
               lpcd_pkg::PH_IDLE: begin
                  phase_in = lpcd_pkg::PH_LENGTH;
               end
               lpcd_pkg::PH_LENGTH: begin
                  if (low_seen_ff) begin
                     if (length_word == 16'd0 || length_word == 16'd1) begin
                        phase_in = lpcd_pkg::PH_IDLE;
                     end else begin
                        phase_in = lpcd_pkg::PH_DATA;
                     end
                  end
               end
               lpcd_pkg::PH_DATA: begin
                  if (data_last) begin
                     phase_in = lpcd_pkg::PH_IDLE;
                  end
               end
               default: begin
                  phase_in = lpcd_pkg::PH_IDLE;
               end
            endcase
         end
      end
   end

   // Frame registers and result word
   always_comb begin
      command_in     = command_ff;
      sf_flag_in     = sf_flag_ff;
      length_high_in = length_high_ff;
      low_seen_in    = low_seen_ff;
      expected_in    = expected_ff;
      count_in       = count_ff;
      field_type_in  = field_type_ff;
      clear_frame    = 1'b0;
      push_valid     = 1'b0;
      push_result    = '{kind: lpcd_pkg::KIND_CMD, code: command_ff, payload: 8'd0, last: 1'b0};
      if (accept) begin
         if (in_abort) begin
            clear_frame = 1'b1;
         end else begin
            unique case (phase_ff)
               lpcd_pkg::PH_IDLE: begin
                  command_in     = in_data;
                  sf_flag_in     = (in_data == struct_code_ff);
                  length_high_in = 8'd0;
                  low_seen_in    = 1'b0;
                  expected_in    = 16'd0;
                  count_in       = 16'd0;
               end
               lpcd_pkg::PH_LENGTH: begin
                  if (!low_seen_ff) begin
                     length_high_in = in_data;
                     low_seen_in    = 1'b1;
                  end else begin
                     expected_in = length_word;
                     low_seen_in = 1'b0;
                     if (length_word == 16'd0) begin
                        sf_flag_in = 1'b0;
                     end else if (length_word == 16'd1) begin
                        push_valid  = 1'b1;
                        push_result = '{kind: lpcd_pkg::KIND_LEN_ERR, code: command_ff,
                                        payload: 8'd0, last: 1'b1};
                        clear_frame = 1'b1;
                     end else begin
                        count_in = 16'(lpcd_pkg::HEADER_BYTES);
                     end
                  end
               end
               lpcd_pkg::PH_DATA: begin
                  count_in = count_next;
                  if (!sf_flag_ff) begin
                     push_valid  = 1'b1;
                     push_result = '{kind: lpcd_pkg::KIND_CMD, code: command_ff,
                                     payload: in_data, last: data_last};
                  end else if (data_index == 16'(lpcd_pkg::SF_TYPE_INDEX)) begin
                     field_type_in = in_data;
                     if (data_last) begin
                        push_valid  = 1'b1;
                        push_result = '{kind: lpcd_pkg::KIND_SF_EMPTY, code: in_data,
                                        payload: 8'd0, last: 1'b1};
                     end
                  end else if (data_index > 16'(lpcd_pkg::SF_TYPE_INDEX)) begin
                     push_valid  = 1'b1;
                     push_result = '{kind: lpcd_pkg::KIND_SF, code: field_type_ff,
                                     payload: in_data, last: data_last};
                  end
                  if (data_last) begin
                     sf_flag_in = 1'b0;
                  end
               end
               default: begin
                  clear_frame = 1'b1;
               end
            endcase
         end
      end
      if (clear_frame) begin
         command_in     = 8'd0;
         sf_flag_in     = 1'b0;
         length_high_in = 8'd0;
         low_seen_in    = 1'b0;
         expected_in    = 16'd0;
         count_in       = 16'd0;
         field_type_in  = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= lpcd_pkg::PH_IDLE;
         struct_code_ff <= 8'(lpcd_pkg::STRUCT_CODE_RST);
         command_ff     <= 8'd0;
         sf_flag_ff     <= 1'b0;
         length_high_ff <= 8'd0;
         low_seen_ff    <= 1'b0;
         expected_ff    <= 16'd0;
         count_ff       <= 16'd0;
         field_type_ff  <= 8'd0;
      end else begin
         phase_ff       <= phase_in;
         command_ff     <= command_in;
         sf_flag_ff     <= sf_flag_in;
         length_high_ff <= length_high_in;
         low_seen_ff    <= low_seen_in;
         expected_ff    <= expected_in;
         count_ff       <= count_in;
         field_type_ff  <= field_type_in;
         if (csr_valid) begin
            struct_code_ff <= csr_data;
         end
      end
   end

`ifndef SYNTHESIS
   a_closing_kinds_last: assert property (@(posedge clock) disable iff (reset)
      push_valid && (push_result.kind == lpcd_pkg::KIND_SF_EMPTY ||
                     push_result.kind == lpcd_pkg::KIND_LEN_ERR) |-> push_result.last)
      else $error("empty field or length error word without last");

   a_abort_to_idle: assert property (@(posedge clock) disable iff (reset)
      accept && in_abort |=> phase_ff == lpcd_pkg::PH_IDLE && !sf_flag_ff)
      else $error("abort did not return parser to idle");

   // A length of two still takes one payload byte, so the count may equal the length
   a_data_phase_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == lpcd_pkg::PH_DATA |-> count_ff >= 16'(lpcd_pkg::HEADER_BYTES)
                                        && count_ff <= expected_ff)
      else $error("payload count out of frame range");
`endif

endmodule

// ----- design/lpcd_queue.sv -----
// Short result queue between the front end and the output stage.
module lpcd_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  lpcd_pkg::result_type    push_result,
   output logic                    not_full,
   output logic                    not_empty,
   input  logic                    pop,
   output lpcd_pkg::result_type    head
);

   lpcd_pkg::result_type                 entry_ff [lpcd_pkg::QUEUE_DEPTH];
   logic [lpcd_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [lpcd_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [lpcd_pkg::QUEUE_CNT_W-1:0]     count_ff, count_in;

   assign not_full  = (count_ff != lpcd_pkg::QUEUE_CNT_W'(lpcd_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == lpcd_pkg::QUEUE_PTR_W'(lpcd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == lpcd_pkg::QUEUE_PTR_W'(lpcd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_result;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> not_full)
      else $error("push into full result queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty result queue");
`endif

endmodule

// ----- design/lpcd_back.sv -----
// Output stage: drains the result queue into the registered result channel.
module lpcd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    queue_not_empty,
   input  lpcd_pkg::result_type    queue_head,
   output logic                    queue_pop,
   output logic                    out_valid,
   input  logic                    out_ready,
   output lpcd_pkg::result_type    out_result
);

   logic                  valid_ff, valid_in;
   lpcd_pkg::result_type  result_ff;

   // Advance when the output slot is empty or its word is taken this cycle
   assign queue_pop  = queue_not_empty & (~valid_ff | out_ready);
   assign valid_in   = queue_pop | (valid_ff & ~out_ready);
   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         result_ff <= queue_head;
      end
   end

endmodule

// ----- design/length_prefixed_command_deframer_top.sv -----
// Top level of the length-prefixed command deframer.
//
// Takes one stream byte per word on the req_ channel and emits at most one
// result word per input byte on the rsp_ channel. A frame is a command byte,
// a big-endian 16-bit length that counts its own two bytes, then the payload
// (at least one byte). Ordinary commands stream every payload byte tagged with
// the command (kind 0). A command equal to the csr_ register (reset 243) is a
// structured field: payload bytes 0 and 1 are dropped, byte 2 is the field
// type, and later bytes stream as kind 1 tagged with the type; a field of
// exactly three payload bytes gives one kind 2 word, shorter ones give nothing.
// Length 0 ends the frame silently, length 1 gives one kind 3 error word.
// A byte with the abort flag set resets the parser and is dropped.
// Rate: one byte per cycle, sustained, as long as results are taken. A result
// passes through the result queue and then the output register before it
// appears on rsp_. The front parser writes into a two-word result queue and an
// output register drains it, so req_tready drops only when the queue is full
// under rsp_ backpressure.
// Write csr_ only while no frame is in progress; csr_ready is always high.
module length_prefixed_command_deframer_top (
   input  logic         clock,
   input  logic         reset,
   // configuration: structured-field command code
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_data,
   // input stream
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,     // [7:0] data_byte
   input  logic         req_tuser,     // [0] abort
   // result stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata,     // [7:0] out_code, [15:8] out_byte
   output logic [1:0]   rsp_tuser,     // [1:0] out_kind
   output logic         rsp_tlast      // out_last
);

   logic                  queue_not_full;
   logic                  queue_not_empty;
   logic                  queue_pop;
   logic                  push_valid;
   lpcd_pkg::result_type  push_result;
   lpcd_pkg::result_type  queue_head;
   lpcd_pkg::result_type  out_result;

   assign csr_ready  = 1'b1;
   // Accept whenever the queue has room; the parser never stalls otherwise
   assign req_tready = queue_not_full;

   lpcd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_data       (csr_data),
      .in_valid       (req_tvalid),
      .in_data        (req_tdata),
      .in_abort       (req_tuser),
      .queue_not_full (queue_not_full),
      .push_valid     (push_valid),
      .push_result    (push_result)
   );

   lpcd_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_result (push_result),
      .not_full    (queue_not_full),
      .not_empty   (queue_not_empty),
      .pop         (queue_pop),
      .head        (queue_head)
   );

   lpcd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .queue_head      (queue_head),
      .queue_pop       (queue_pop),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_result      (out_result)
   );

   // Pack the result word onto the stream fields
   assign rsp_tdata = {out_result.payload, out_result.code};
   assign rsp_tuser = out_result.kind;
   assign rsp_tlast = out_result.last;

endmodule
